/* rtl/multi_timer_table_unit_assert.svh */
// Assertion macros shared by the timer table checker.
`ifndef MULTI_TIMER_TABLE_UNIT_ASSERT_SVH
`define MULTI_TIMER_TABLE_UNIT_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define MTT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("timer table: same-cycle property failed");

// Consequent holds in the cycle after the antecedent.
`define MTT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("timer table: next-cycle property failed");

`endif

/* rtl/mtt_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Timer table package
// Request codes, status codes, widths and the slot record layout.
// ---------------------------------------------------------------------------
package mtt_pkg;

  localparam int unsigned TimersDefault = 16;
  localparam int unsigned MaxResults    = 16;
  localparam int unsigned BufAw         = $clog2(MaxResults);

  localparam logic [31:0] NeverTime = 32'hFFFF_FFFF;
  localparam logic [30:0] TillCap   = 31'h7FFF_FFFF;

  // request types
  localparam logic [3:0] ReqStart      = 4'd0;
  localparam logic [3:0] ReqDelay      = 4'd1;
  localparam logic [3:0] ReqDelayUntil = 4'd2;
  localparam logic [3:0] ReqPauseOne   = 4'd3;
  localparam logic [3:0] ReqUnpauseOne = 4'd4;
  localparam logic [3:0] ReqPauseAll   = 4'd5;
  localparam logic [3:0] ReqUnpauseAll = 4'd6;
  localparam logic [3:0] ReqCancel     = 4'd7;
  localparam logic [3:0] ReqCancelAll  = 4'd8;
  localparam logic [3:0] ReqQuery      = 4'd9;
  localparam logic [3:0] ReqCheck      = 4'd10;

  // status codes
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;
  localparam logic [1:0] StZeroId   = 2'd3;

  // result kinds
  localparam logic KindFired  = 1'b0;
  localparam logic KindAnswer = 1'b1;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] interval;
    logic [31:0] fire;
    logic        once;
    logic        paused;
  } slot_t;

endpackage

/* rtl/mtt_slot_mem.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Timer slot memory
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module mtt_slot_mem
  import mtt_pkg::*;
#(
  parameter int unsigned Depth = TimersDefault,
  parameter int unsigned Aw    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  slot_t         wdata_i,
  input  logic [Aw-1:0] raddr_i,
  output slot_t         rdata_o
);

  slot_t mem_q [Depth];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/multi_timer_table_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Multi timer table
// Table of millisecond timers: start, delay, pause, cancel, query and check.
// ---------------------------------------------------------------------------
// Channel | Dir | tdata (low bit up)                          | tuser     | tlast
// s_axis  | in  | timer_id, amount, one_shot, now (88 b)      | req_type  | -
// m_axis  | out | status, fired_id, elapsed_ms, next_fire,    | kind      | last
//         |     | is_paused, till_next, all_paused (120 b)    |           |
//
// One request at a time. A find pass reads every slot, a single-slot update
// follows, then the time-till-next pass; pause-all, unpause-all and check
// replace find and update by a rewrite pass, cancel-all by clearing every
// valid bit. Each fired timer is read from the result buffer, then loaded
// into the output register before the next is read. The slot memory port
// sets the pass lengths: one slot read per cycle.
// Reset clears the valid bits and the pause-all flag; no clearing pass.
// A stalled result holds in the output register; the next request may be
// taken while the final result of the previous one still waits.
// ---------------------------------------------------------------------------
module multi_timer_table_unit
  import mtt_pkg::*;
#(
  parameter int unsigned TIMERS = TimersDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [87:0]  s_axis_tdata,   // timer_id, amount, one_shot, now, pad
  input  logic [3:0]   s_axis_tuser,   // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata,   // status, fired_id, elapsed_ms, next_fire,
                                       // is_paused, till_next, all_paused, pad
  output logic         m_axis_tuser,   // kind
  output logic         m_axis_tlast
);

  localparam int unsigned Aw = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam logic [Aw-1:0] LastSlot = Aw'(TIMERS - 1);

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_FIND     = 4'd1;
  localparam logic [3:0] S_FIND_END = 4'd2;
  localparam logic [3:0] S_OP       = 4'd3;
  localparam logic [3:0] S_OP_WR    = 4'd4;
  localparam logic [3:0] S_WALK     = 4'd5;
  localparam logic [3:0] S_WALK_END = 4'd6;
  localparam logic [3:0] S_TILL     = 4'd7;
  localparam logic [3:0] S_TILL_END = 4'd8;
  localparam logic [3:0] S_EM_RD    = 4'd9;
  localparam logic [3:0] S_EM_LD    = 4'd10;
  localparam logic [3:0] S_EM_ANS   = 4'd11;

  // which pass the returning read data belongs to
  localparam logic [1:0] P_FIND = 2'd0;
  localparam logic [1:0] P_WALK = 2'd1;
  localparam logic [1:0] P_TILL = 2'd2;

  logic [3:0]  state_q, state_d;
  logic [1:0]  pass_q, pass_d;

  // request hold
  logic [3:0]  req_q, req_d;
  logic [15:0] id_q, id_d;
  logic [31:0] amt_q, amt_d;
  logic        once_q, once_d;
  logic [31:0] now_q, now_d;

  logic [TIMERS-1:0] valid_q, valid_d;
  logic              gpause_q, gpause_d;

  // scan pipeline
  logic [Aw-1:0] scan_q, scan_d;
  logic          pv_q, pv_d;
  logic [Aw-1:0] pa_q, pa_d;

  // find results
  logic          found_q, found_d;
  logic [Aw-1:0] hit_q, hit_d;
  logic          free_ok_q, free_ok_d;
  logic [Aw-1:0] free_q, free_d;

  logic [30:0] best_q, best_d;

  // answer record
  logic [1:0]  ans_st_q, ans_st_d;
  logic [15:0] ans_id_q, ans_id_d;
  logic [31:0] ans_nx_q, ans_nx_d;
  logic        ans_pz_q, ans_pz_d;

  // fired result buffer
  logic [BufAw:0]   cnt_q, cnt_d;
  logic [BufAw-1:0] emk_q, emk_d;
  logic [47:0]      buf_mem_q [MaxResults];
  logic [47:0]      buf_rd_q;
  logic             buf_we;
  logic [47:0]      buf_wd;

  // output register
  logic        ov_q, ov_d;
  logic        ok_q, ok_d;
  logic [1:0]  ost_q, ost_d;
  logic [15:0] oid_q, oid_d;
  logic [31:0] oel_q, oel_d;
  logic [31:0] onx_q, onx_d;
  logic        opz_q, opz_d;
  logic [30:0] otl_q, otl_d;
  logic        oap_q, oap_d;
  logic        olast_q, olast_d;

  // slot memory port
  logic          mem_we;
  logic [Aw-1:0] mem_wa, mem_ra;
  slot_t         mem_wd, mem_rd;

  mtt_slot_mem #(
    .Depth (TIMERS),
    .Aw    (Aw)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_wa),
    .wdata_i (mem_wd),
    .raddr_i (mem_ra),
    .rdata_o (mem_rd)
  );

  logic        out_free;
  logic        pvalid;
  logic        due;
  logic [31:0] diff;

  assign out_free = !ov_q || m_axis_tready;
  assign pvalid   = pv_q && valid_q[pa_q];
  assign due      = now_q >= mem_rd.fire;
  assign diff     = mem_rd.fire - now_q;

  always_comb begin
    state_d   = state_q;
    pass_d    = pass_q;
    req_d     = req_q;
    id_d      = id_q;
    amt_d     = amt_q;
    once_d    = once_q;
    now_d     = now_q;
    valid_d   = valid_q;
    gpause_d  = gpause_q;
    scan_d    = scan_q;
    pv_d      = 1'b0;
    pa_d      = pa_q;
    found_d   = found_q;
    hit_d     = hit_q;
    free_ok_d = free_ok_q;
    free_d    = free_q;
    best_d    = best_q;
    ans_st_d  = ans_st_q;
    ans_id_d  = ans_id_q;
    ans_nx_d  = ans_nx_q;
    ans_pz_d  = ans_pz_q;
    cnt_d     = cnt_q;
    emk_d     = emk_q;
    ov_d      = ov_q;
    ok_d      = ok_q;
    ost_d     = ost_q;
    oid_d     = oid_q;
    oel_d     = oel_q;
    onx_d     = onx_q;
    opz_d     = opz_q;
    otl_d     = otl_q;
    oap_d     = oap_q;
    olast_d   = olast_q;
    mem_we    = 1'b0;
    mem_wa    = pa_q;
    mem_wd    = mem_rd;
    mem_ra    = scan_q;
    buf_we    = 1'b0;
    buf_wd    = {mem_rd.id, (now_q - mem_rd.fire) + mem_rd.interval};

    // drop a result the sink has taken
    if (ov_q && m_axis_tready) begin
      ov_d = 1'b0;
    end

    // process the slot read issued last cycle
    if (pv_q) begin
      case (pass_q)
        P_FIND: begin
          if (pvalid && (mem_rd.id == id_q) && !found_q) begin
            found_d = 1'b1;
            hit_d   = pa_q;
          end
          if (!valid_q[pa_q] && !free_ok_q) begin
            free_ok_d = 1'b1;
            free_d    = pa_q;
          end
        end
        P_WALK: begin
          case (req_q)
            ReqPauseAll: begin
              if (pvalid && !mem_rd.paused) begin
                mem_we        = 1'b1;
                mem_wd.fire   = (mem_rd.fire > now_q) ? diff : 32'd0;
                mem_wd.paused = 1'b1;
              end
            end
            ReqUnpauseAll: begin
              if (pvalid && mem_rd.paused) begin
                mem_we        = 1'b1;
                mem_wd.fire   = now_q + mem_rd.fire;
                mem_wd.paused = 1'b0;
              end
            end
            default: begin
              // check: fire due timers while the buffer has room
              if (pvalid && !mem_rd.paused && due &&
                  (cnt_q < (BufAw + 1)'(MaxResults))) begin
                buf_we = 1'b1;
                cnt_d  = cnt_q + 1'b1;
                if (mem_rd.once) begin
                  valid_d[pa_q] = 1'b0;
                end else begin
                  mem_we      = 1'b1;
                  mem_wd.fire = now_q + mem_rd.interval;
                end
              end
            end
          endcase
        end
        default: begin
          if (pvalid && !mem_rd.paused) begin
            if (due) begin
              best_d = '0;
            end else if (diff < {1'b0, best_q}) begin
              best_d = diff[30:0];
            end
          end
        end
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          req_d     = s_axis_tuser;
          id_d      = s_axis_tdata[15:0];
          amt_d     = s_axis_tdata[47:16];
          once_d    = s_axis_tdata[48];
          now_d     = s_axis_tdata[80:49];
          scan_d    = '0;
          found_d   = 1'b0;
          free_ok_d = 1'b0;
          best_d    = TillCap;
          cnt_d     = '0;
          ans_st_d  = StOk;
          ans_id_d  = s_axis_tdata[15:0];
          ans_nx_d  = '0;
          ans_pz_d  = 1'b0;
          case (s_axis_tuser)
            ReqPauseAll, ReqUnpauseAll, ReqCheck: begin
              ans_id_d = '0;
              gpause_d = (s_axis_tuser == ReqPauseAll) ? 1'b1 :
                         (s_axis_tuser == ReqUnpauseAll) ? 1'b0 : gpause_q;
              pass_d   = P_WALK;
              state_d  = S_WALK;
            end
            ReqCancelAll: begin
              ans_id_d = '0;
              valid_d  = '0;
              pass_d   = P_TILL;
              state_d  = S_TILL;
            end
            default: begin
              pass_d  = P_FIND;
              state_d = S_FIND;
            end
          endcase
        end
      end

      S_FIND, S_WALK, S_TILL: begin
        mem_ra = scan_q;
        pv_d   = 1'b1;
        pa_d   = scan_q;
        if (scan_q == LastSlot) begin
          scan_d  = '0;
          state_d = (state_q == S_FIND) ? S_FIND_END :
                    (state_q == S_WALK) ? S_WALK_END : S_TILL_END;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end

      S_FIND_END: state_d = S_OP;

      S_WALK_END: begin
        pass_d  = P_TILL;
        state_d = S_TILL;
      end

      S_OP: begin
        pass_d  = P_TILL;
        state_d = S_TILL;
        mem_ra  = hit_q;
        pa_d    = hit_q;
        case (req_q)
          ReqStart: begin
            if (id_q == 16'd0) begin
              ans_st_d = StZeroId;
            end else if (found_q || free_ok_q) begin
              mem_we        = 1'b1;
              mem_wa        = found_q ? hit_q : free_q;
              mem_wd.id     = id_q;
              mem_wd.interval = amt_q;
              mem_wd.fire   = amt_q + now_q;
              mem_wd.once   = once_q;
              mem_wd.paused = 1'b0;
              valid_d[found_q ? hit_q : free_q] = 1'b1;
            end else begin
              ans_st_d = StFull;
            end
          end
          ReqDelay, ReqDelayUntil, ReqPauseOne, ReqUnpauseOne, ReqQuery: begin
            if (found_q) begin
              state_d = S_OP_WR;
            end else begin
              ans_st_d = StNotFound;
              if (req_q == ReqQuery) begin
                ans_nx_d = NeverTime;
              end
            end
          end
          ReqCancel: begin
            if (found_q) begin
              valid_d[hit_q] = 1'b0;
            end else begin
              ans_st_d = StNotFound;
            end
          end
          default: ;
        endcase
      end

      S_OP_WR: begin
        pass_d  = P_TILL;
        state_d = S_TILL;
        mem_wa  = hit_q;
        case (req_q)
          ReqDelay: begin
            mem_we      = 1'b1;
            mem_wd.fire = mem_rd.fire + amt_q;
          end
          ReqDelayUntil: begin
            mem_we        = 1'b1;
            mem_wd.paused = 1'b0;
            if (mem_rd.fire < amt_q) begin
              mem_wd.fire = amt_q;
            end
          end
          ReqPauseOne: begin
            if (!mem_rd.paused) begin
              mem_we        = 1'b1;
              mem_wd.fire   = (mem_rd.fire > now_q) ? diff : 32'd0;
              mem_wd.paused = 1'b1;
            end
          end
          ReqUnpauseOne: begin
            if (mem_rd.paused) begin
              mem_we        = 1'b1;
              mem_wd.fire   = now_q + mem_rd.fire;
              mem_wd.paused = 1'b0;
            end
          end
          default: begin
            ans_pz_d = mem_rd.paused;
            ans_nx_d = mem_rd.paused ? NeverTime : mem_rd.fire;
          end
        endcase
      end

      S_TILL_END: begin
        emk_d   = '0;
        state_d = (cnt_q == '0) ? S_EM_ANS : S_EM_RD;
      end

      S_EM_RD: state_d = S_EM_LD;

      S_EM_LD: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ok_d    = KindFired;
          ost_d   = StOk;
          oid_d   = buf_rd_q[47:32];
          oel_d   = buf_rd_q[31:0];
          onx_d   = '0;
          opz_d   = 1'b0;
          otl_d   = best_q;
          oap_d   = gpause_q;
          olast_d = ({1'b0, emk_q} == (cnt_q - 1'b1));
          if ({1'b0, emk_q} == (cnt_q - 1'b1)) begin
            state_d = S_IDLE;
          end else begin
            emk_d   = emk_q + 1'b1;
            state_d = S_EM_RD;
          end
        end
      end

      S_EM_ANS: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ok_d    = KindAnswer;
          ost_d   = ans_st_q;
          oid_d   = ans_id_q;
          oel_d   = '0;
          onx_d   = ans_nx_q;
          opz_d   = ans_pz_q;
          otl_d   = best_q;
          oap_d   = gpause_q;
          olast_d = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // fired result buffer: write while walking, read while emitting
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_mem_q[cnt_q[BufAw-1:0]] <= buf_wd;
    end
    buf_rd_q <= buf_mem_q[emk_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= '0;
      gpause_q <= 1'b0;
      pv_q     <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      gpause_q <= gpause_d;
      pv_q     <= pv_d;
      ov_q     <= ov_d;
    end
  end

  // payload and bookkeeping, no reset needed
  always_ff @(posedge clk_i) begin
    pass_q    <= pass_d;
    req_q     <= req_d;
    id_q      <= id_d;
    amt_q     <= amt_d;
    once_q    <= once_d;
    now_q     <= now_d;
    scan_q    <= scan_d;
    pa_q      <= pa_d;
    found_q   <= found_d;
    hit_q     <= hit_d;
    free_ok_q <= free_ok_d;
    free_q    <= free_d;
    best_q    <= best_d;
    ans_st_q  <= ans_st_d;
    ans_id_q  <= ans_id_d;
    ans_nx_q  <= ans_nx_d;
    ans_pz_q  <= ans_pz_d;
    cnt_q     <= cnt_d;
    emk_q     <= emk_d;
    ok_q      <= ok_d;
    ost_q     <= ost_d;
    oid_q     <= oid_d;
    oel_q     <= oel_d;
    onx_q     <= onx_d;
    opz_q     <= opz_d;
    otl_q     <= otl_d;
    oap_q     <= oap_d;
    olast_q   <= olast_d;
  end

  // time-till-next and pause flag travel in the output register, so a
  // waiting result holds while the next request is processed
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = ok_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {5'd0, oap_q, otl_q, opz_q, onx_q, oel_q, oid_q, ost_q};

endmodule

/* rtl/mtt_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Timer table port checker
// Watches the top-level ports and flags result and handshake slips.
// ---------------------------------------------------------------------------
`include "multi_timer_table_unit_assert.svh"

module mtt_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [87:0]  s_axis_tdata,
  input logic [3:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [119:0] m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         m_axis_tlast
);

  // a stalled result holds
  `MTT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // one request at a time: ready drops after a request is taken
  `MTT_ASSERT_NEXT(a_one_req, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // a fired timer always carries status ok
  `MTT_ASSERT_SAME(a_fired_ok, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[1:0] == 2'd0)

  // a paused query answer reports no fire time
  `MTT_ASSERT_SAME(a_paused_never, m_axis_tvalid && m_axis_tdata[82], m_axis_tdata[81:50] == 32'hFFFF_FFFF)

endmodule

bind multi_timer_table_unit mtt_checker u_mtt_checker (.*);
